@@ hw/rtl/jst_pkg.sv @@
`default_nettype none

package jst_pkg;

  localparam int MAX_DEGREE     = 16;
  localparam int COEF_WIDTH     = 32;
  localparam int IN_W           = 32;
  localparam int STORE_DEPTH    = MAX_DEGREE + 1;
  localparam int OVERFLOW_COUNT = MAX_DEGREE + 2;
  localparam int IDX_W          = $clog2(STORE_DEPTH);
  localparam int COUNT_W        = $clog2(OVERFLOW_COUNT + 1);
  localparam int SUM_W          = COEF_WIDTH + IDX_W + 1;

  // Rows are scaled so that every entry fits a signed LIMIT_BITS+1 operand.
  localparam int LIMIT_BITS     = 30;
  localparam int MUL_W          = LIMIT_BITS + 1;
  localparam int PROD_W         = 2 * MUL_W;
  localparam int ROW_W          = (COEF_WIDTH > PROD_W) ? COEF_WIDTH : PROD_W;
  localparam int SHIFT_W        = $clog2(ROW_W);

  // Two row banks, each indexed by IDX_W bits.
  localparam int ADDR_W         = IDX_W + 1;
  localparam int RAM_DEPTH      = 2 ** ADDR_W;

  // Shortest coefficient list that needs any table reduction (degree three).
  localparam int MIN_REDUCE_LEN = 4;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_CHECK,
    ST_NSTART,
    ST_NWAIT,
    ST_RD0,
    ST_RDM,
    ST_CAPM,
    ST_RDA,
    ST_RDB,
    ST_MB,
    ST_P1,
    ST_SUB,
    ST_WR,
    ST_MAG,
    ST_CMP,
    ST_DONE
  } jst_state_e;

  typedef struct packed {
    logic               done;
    logic [SHIFT_W-1:0] shift;
  } norm_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/jst_ram.sv @@
`default_nettype none

module jst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ hw/rtl/jst_norm.sv @@
`default_nettype none

// Finds the right shift that brings a folded row magnitude below 2**LIMIT_BITS,
// one bit per cycle.
module jst_norm (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [jst_pkg::ROW_W-1:0]      word_i,
  output jst_pkg::norm_stat_t            stat_o
);

  localparam int RW = jst_pkg::ROW_W;
  localparam int SW = jst_pkg::SHIFT_W;

  logic          busy_q;
  logic [RW-1:0] word_q;
  logic [SW-1:0] shift_q;
  logic          high_set;

  assign high_set = |word_q[RW-1:jst_pkg::LIMIT_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (busy_q && !high_set) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      word_q  <= word_i;
      shift_q <= '0;
    end else if (busy_q && high_set) begin
      word_q  <= word_q >> 1;
      shift_q <= shift_q + SW'(1);
    end
  end

  assign stat_o.done  = busy_q && !high_set;
  assign stat_o.shift = shift_q;

endmodule

`default_nettype wire

@@ hw/rtl/jst_mul.sv @@
`default_nettype none

// Shared signed multiplier: operands registered, product registered.
module jst_mul (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [jst_pkg::MUL_W-1:0]   a_i,
  input  logic signed [jst_pkg::MUL_W-1:0]   b_i,
  output logic signed [jst_pkg::PROD_W-1:0]  product_o
);

  logic signed [jst_pkg::MUL_W-1:0] a_q;
  logic signed [jst_pkg::MUL_W-1:0] b_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end
    product_o <= a_q * b_q;
  end

endmodule

`default_nettype wire

@@ hw/rtl/jury_stability_test.sv @@
// Jury stability test on a polynomial with Q16.16 coefficients.
// Input channel (in_valid_i / in_ready_o): one coefficient per transfer, leading
// coefficient first; last_coefficient_i marks the constant term. Coefficients
// load at one per cycle; more than MAX_DEGREE+1 of them make the result 0.
// Output channel (out_valid_o / out_ready_i): one stable_flag_o transfer for each
// polynomial, once its test has finished.
// After the last transfer a check state runs, then for degree three and up, at
// most n-2 table reductions on one shared multiplier. Each reduction first finds
// the row's scale shift one bit per cycle, reads the row's first and last
// entries, then forms each new entry from two reads, two products and a
// subtraction and writes it to the other bank. The result then passes through
// the done state into the output register.
// in_ready_o is high while coefficients load and low from the last transfer
// until the result has entered the output register. A stalled receiver holds
// the result there; the next polynomial may load meanwhile, and its own result
// waits until the previous one has been taken.
// Reset clears the sequencer, the coefficient count and sums and the output
// valid; the row store needs no clearing.
`default_nettype none

module jury_stability_test (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [jst_pkg::IN_W-1:0]  coefficient_i,
  input  logic                      last_coefficient_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      stable_flag_o
);

  localparam int CW  = jst_pkg::COEF_WIDTH;
  localparam int CW1 = CW + 1;
  localparam int RW  = jst_pkg::ROW_W;
  localparam int SW  = jst_pkg::SUM_W;
  localparam int MW  = jst_pkg::MUL_W;
  localparam int IW  = jst_pkg::IDX_W;
  localparam int NW  = jst_pkg::COUNT_W;
  localparam int AW  = jst_pkg::ADDR_W;

  // Fold a value so that its bit length is that of the value as a signed number, sign bit apart.
  function automatic logic [RW-1:0] fold(input logic [RW-1:0] v);
    fold = v[RW-1] ? ~v : v;
  endfunction

  function automatic logic [RW-1:0] mag(input logic [RW-1:0] v);
    mag = v[RW-1] ? (~v + RW'(1)) : v;
  endfunction

  jst_pkg::jst_state_e state_q, state_d;

  // Coefficient intake
  logic [NW-1:0]        count_q;
  logic signed [SW-1:0] sum_q;
  logic signed [SW-1:0] alt_q;
  logic signed [CW-1:0] a0_q;
  logic signed [CW-1:0] an_q;
  logic [RW-1:0]        or_q;

  // Reduction sequencer
  logic [NW-1:0]        len_q;
  logic [NW-1:0]        rows_q;
  logic                 bank_q;
  logic [IW-1:0]        i_q;
  logic signed [MW-1:0] r0_q;
  logic signed [MW-1:0] rm_q;
  logic signed [RW-1:0] p1_q;
  logic signed [RW-1:0] diff_q;
  logic signed [RW-1:0] first_q;
  logic [RW-1:0]        first_mag_q;
  logic [RW-1:0]        last_mag_q;

  // Result
  logic res_q, res_d, res_set;
  logic out_valid_q;
  logic stable_flag_q;
  logic load_out;

  logic                 accept;
  logic                 store;
  logic signed [CW-1:0] coef_val;
  logic signed [RW-1:0] coef_row;
  logic signed [SW-1:0] coef_sum;
  logic signed [CW1-1:0] pair_sum;
  logic                 checks_pass;
  logic [IW-1:0]        m_idx;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [RW-1:0]        ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [RW-1:0]        ram_rdata;
  logic signed [RW-1:0] rd_shift;
  logic signed [MW-1:0] rd_op;

  logic                               mul_en;
  logic signed [MW-1:0]               mul_a;
  logic signed [MW-1:0]               mul_b;
  logic signed [jst_pkg::PROD_W-1:0]  mul_prod;

  logic                 norm_start;
  jst_pkg::norm_stat_t  norm_stat;

  assign accept   = in_valid_i && in_ready_o;
  assign store    = count_q < NW'(jst_pkg::STORE_DEPTH);
  assign coef_val = $signed(CW'(coefficient_i));
  assign coef_row = RW'(coef_val);
  assign coef_sum = SW'(coef_val);
  assign m_idx    = IW'(len_q - NW'(1));

  // |a[n]| < a[0] as two independent compares, then both sums positive.
  assign pair_sum    = CW1'(an_q) + CW1'(a0_q);
  assign checks_pass = (an_q < a0_q) && !pair_sum[CW] && (pair_sum != '0) &&
                       !sum_q[SW-1] && (sum_q != '0) &&
                       !alt_q[SW-1] && (alt_q != '0);

  // Scale each row entry on its way out of the store.
  assign rd_shift = $signed(ram_rdata) >>> norm_stat.shift;
  assign rd_op    = rd_shift[MW-1:0];

  jst_ram #(
    .WIDTH (RW),
    .DEPTH (jst_pkg::RAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  jst_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (norm_start),
    .word_i  (or_q),
    .stat_o  (norm_stat)
  );

  jst_mul u_mul (
    .clk_i     (clk_i),
    .en_i      (mul_en),
    .a_i       (mul_a),
    .b_i       (mul_b),
    .product_o (mul_prod)
  );

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = diff_q;
    ram_raddr  = '0;
    mul_en     = 1'b0;
    mul_a      = rm_q;
    mul_b      = rd_op;
    norm_start = 1'b0;
    load_out   = 1'b0;
    res_set    = 1'b0;
    res_d      = 1'b0;
    case (state_q)
      jst_pkg::ST_LOAD: begin
        in_ready_o = 1'b1;
        if (accept && store) begin
          ram_we    = 1'b1;
          ram_waddr = {1'b0, count_q[IW-1:0]};
          ram_wdata = coef_row;
        end
        if (accept && last_coefficient_i) begin
          state_d = jst_pkg::ST_CHECK;
        end
      end
      jst_pkg::ST_CHECK: begin
        if (count_q > NW'(jst_pkg::STORE_DEPTH) || !checks_pass) begin
          res_set = 1'b1;
          res_d   = 1'b0;
          state_d = jst_pkg::ST_DONE;
        end else if (count_q < NW'(jst_pkg::MIN_REDUCE_LEN)) begin
          res_set = 1'b1;
          res_d   = 1'b1;
          state_d = jst_pkg::ST_DONE;
        end else begin
          state_d = jst_pkg::ST_NSTART;
        end
      end
      jst_pkg::ST_NSTART: begin
        norm_start = 1'b1;
        state_d    = jst_pkg::ST_NWAIT;
      end
      jst_pkg::ST_NWAIT: begin
        if (norm_stat.done) begin
          state_d = jst_pkg::ST_RD0;
        end
      end
      jst_pkg::ST_RD0: begin
        ram_raddr = {bank_q, IW'(0)};
        state_d   = jst_pkg::ST_RDM;
      end
      jst_pkg::ST_RDM: begin
        ram_raddr = {bank_q, m_idx};
        state_d   = jst_pkg::ST_CAPM;
      end
      jst_pkg::ST_CAPM: begin
        state_d = jst_pkg::ST_RDA;
      end
      jst_pkg::ST_RDA: begin
        ram_raddr = {bank_q, i_q + IW'(1)};
        state_d   = jst_pkg::ST_RDB;
      end
      jst_pkg::ST_RDB: begin
        ram_raddr = {bank_q, m_idx - IW'(1) - i_q};
        mul_en    = 1'b1;
        mul_a     = rm_q;
        state_d   = jst_pkg::ST_MB;
      end
      jst_pkg::ST_MB: begin
        mul_en  = 1'b1;
        mul_a   = r0_q;
        state_d = jst_pkg::ST_P1;
      end
      jst_pkg::ST_P1: begin
        state_d = jst_pkg::ST_SUB;
      end
      jst_pkg::ST_SUB: begin
        state_d = jst_pkg::ST_WR;
      end
      jst_pkg::ST_WR: begin
        ram_we    = 1'b1;
        ram_waddr = {~bank_q, i_q};
        ram_wdata = diff_q;
        if (i_q == m_idx - IW'(1)) begin
          state_d = jst_pkg::ST_MAG;
        end else begin
          state_d = jst_pkg::ST_RDA;
        end
      end
      jst_pkg::ST_MAG: begin
        state_d = jst_pkg::ST_CMP;
      end
      jst_pkg::ST_CMP: begin
        if (last_mag_q <= first_mag_q) begin
          res_set = 1'b1;
          res_d   = 1'b0;
          state_d = jst_pkg::ST_DONE;
        end else if (rows_q == NW'(1)) begin
          res_set = 1'b1;
          res_d   = 1'b1;
          state_d = jst_pkg::ST_DONE;
        end else begin
          state_d = jst_pkg::ST_NSTART;
        end
      end
      jst_pkg::ST_DONE: begin
        // Hold the result until the output register is free.
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = jst_pkg::ST_LOAD;
        end
      end
      default: begin
        state_d = jst_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= jst_pkg::ST_LOAD;
      count_q     <= '0;
      sum_q       <= '0;
      alt_q       <= '0;
      or_q        <= '0;
      len_q       <= '0;
      rows_q      <= '0;
      bank_q      <= 1'b0;
      i_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (accept) begin
        if (store) begin
          count_q <= count_q + NW'(1);
          sum_q   <= sum_q + coef_sum;
          alt_q   <= count_q[0] ? (alt_q - coef_sum) : (alt_q + coef_sum);
          or_q    <= or_q | fold(coef_row);
        end else begin
          // Drop extra coefficients and mark the polynomial as overlong.
          count_q <= NW'(jst_pkg::OVERFLOW_COUNT);
        end
      end

      if (load_out) begin
        count_q <= '0;
        sum_q   <= '0;
        alt_q   <= '0;
        or_q    <= '0;
      end

      case (state_q)
        jst_pkg::ST_CHECK: begin
          len_q  <= count_q;
          rows_q <= count_q - NW'(jst_pkg::MIN_REDUCE_LEN - 1);
          bank_q <= 1'b0;
        end
        jst_pkg::ST_NSTART: begin
          or_q <= '0;
        end
        jst_pkg::ST_CAPM: begin
          i_q <= '0;
        end
        jst_pkg::ST_WR: begin
          or_q <= or_q | fold(diff_q);
          i_q  <= i_q + IW'(1);
        end
        jst_pkg::ST_CMP: begin
          bank_q <= ~bank_q;
          len_q  <= len_q - NW'(1);
          rows_q <= rows_q - NW'(1);
        end
        default: begin
        end
      endcase

      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      an_q <= coef_val;
      if (count_q == '0) begin
        a0_q <= coef_val;
      end
    end

    case (state_q)
      jst_pkg::ST_RDM:  r0_q        <= rd_op;
      jst_pkg::ST_CAPM: rm_q        <= rd_op;
      jst_pkg::ST_P1:   p1_q        <= RW'(mul_prod);
      jst_pkg::ST_SUB:  diff_q      <= p1_q - RW'(mul_prod);
      jst_pkg::ST_WR: begin
        if (i_q == '0) begin
          first_q <= diff_q;
        end
      end
      jst_pkg::ST_MAG: begin
        first_mag_q <= mag(first_q);
        last_mag_q  <= mag(diff_q);
      end
      default: begin
      end
    endcase

    if (res_set) begin
      res_q <= res_d;
    end
    if (load_out) begin
      stable_flag_q <= res_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign stable_flag_o = stable_flag_q;

endmodule

`default_nettype wire

@@ hw/rtl/jst_checker.sv @@
`default_nettype none

module jst_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic last_coefficient_i,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic stable_flag_o
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(stable_flag_o))
    else $error("result changed while stalled");

  // The constant term ends the load; the test then runs with intake closed.
  a_busy_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && last_coefficient_i |=> !in_ready_o)
    else $error("intake open right after the constant term");

  // Coefficients before the constant term stream without a gap in readiness.
  a_ready_mid_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !last_coefficient_i |=> in_ready_o)
    else $error("intake closed in the middle of a polynomial");

  // A new result only comes out of a finished test, never during the load.
  a_result_from_test: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared while loading");

endmodule

bind jury_stability_test jst_checker u_jst_checker (.*);

`default_nettype wire
